[rtl/core/sevseg_pkg.sv]
// Shared types and constants for the seven-segment scan/blink/scroll driver.
// No dependencies; imported by seven_segment_scan_blink_scroll.
`default_nettype none

package sevseg_pkg;

	// Display size: digit count and message length (port widths fit these)
	localparam int NUM_DIGITS    = 4;
	localparam int MESSAGE_CHARS = 8;

	// Request function codes
	typedef enum logic [2:0] {
		FUNC_TICK       = 3'd0,
		FUNC_WR_DIGIT   = 3'd1,
		FUNC_WR_DOT     = 3'd2,
		FUNC_LOAD_CHAR  = 3'd3,
		FUNC_START_SCRL = 3'd4,
		FUNC_STOP_SCRL  = 3'd5
	} func_t;

	// Configuration register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_BRIGHTNESS  = 3'd0,
		REG_SCAN_PERIOD = 3'd1,
		REG_BLINK_PER   = 3'd2,
		REG_SCROLL_PER  = 3'd3,
		REG_BLINK_EN    = 3'd4,
		REG_BLINK_DIGIT = 3'd5
	} reg_idx_t;

	localparam int ADDR_W = 5;

	// Brightness level at or above which dimming is off
	localparam int BRIGHT_MAX = 15;

	// Reset values
	localparam logic [3:0]  BRIGHT_RST      = 4'd15;
	localparam logic [7:0]  SCAN_PER_RST    = 8'd2;
	localparam logic [15:0] BLINK_PER_RST   = 16'd500;
	localparam logic [15:0] SCROLL_PER_RST  = 16'd500;
	localparam logic [6:0]  ALL_SEGS_ON     = 7'h7F;
	localparam logic [7:0]  SCROLL_LIM_RST  = 8'd1;

endpackage : sevseg_pkg

`default_nettype wire

[rtl/core/seven_segment_scan_blink_scroll.sv]
// Multiplexed seven-segment driver with blink, dimming and message scroll.
// Depends on sevseg_pkg (sizes, function codes, register indexes, reset values).
`default_nettype none

// Every request (tick or write) is applied and its result, the current drive
// state, sits in an output register; one request per cycle is taken as long
// as the result side keeps up (in_stall rises only while a result is held
// under out_stall). Ticks run blink, scan, dimming and scroll in that order.
// The scroll window is a NUM_DIGITS-wide register that shifts in one message
// character per advance, so each advance reads the message store at a single
// address. Configuration is on a small APB port, one 32-bit register every 4
// bytes; write it only while the driver is idle, the block does not enforce it.
module seven_segment_scan_blink_scroll
	import sevseg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// APB configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready,
	// request channel
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [2:0]        func,
	input  wire logic [1:0]        digit,
	input  wire logic [6:0]        pattern,
	input  wire logic              dot_level,
	input  wire logic [2:0]        char_index,
	input  wire logic [7:0]        repeat_count,
	// result channel
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic [1:0]        digit_select,
	output      logic [6:0]        segments,
	output      logic              dot_out,
	output      logic              dimmed,
	output      logic              scroll_busy
);

	localparam int DIG_W    = $clog2(NUM_DIGITS);
	localparam int CH_W     = $clog2(MESSAGE_CHARS);
	localparam int LEAD     = NUM_DIGITS - 1;
	localparam int LAST_POS = MESSAGE_CHARS + NUM_DIGITS - 1;
	localparam int POS_W    = $clog2(LAST_POS + 1);

	// configuration registers
	logic [3:0]  brightness_q;
	logic [7:0]  scan_period_q;
	logic [15:0] blink_period_q;
	logic [15:0] scroll_period_q;
	logic        blink_en_q;
	logic [1:0]  blink_digit_q;

	// display state
	logic [6:0]            pat_q [NUM_DIGITS];
	logic [NUM_DIGITS-1:0] dots_q;
	logic [NUM_DIGITS-1:0] vis_q;
	logic [6:0]            chars_q [MESSAGE_CHARS];
	logic [6:0]            win_q [NUM_DIGITS];
	logic [DIG_W-1:0]      scan_index_q;
	logic [7:0]            scan_timer_q;
	logic [3:0]            dim_q;
	logic                  lit_q;
	logic [15:0]           blink_timer_q;
	logic [15:0]           scroll_timer_q;
	logic [POS_W-1:0]      pos_q;
	logic [7:0]            passes_q;
	logic [7:0]            limit_q;
	logic                  active_q;
	logic                  out_valid_q;

	// drive latch (also the result payload)
	logic [1:0] sel_q;
	logic [6:0] seg_q;
	logic       dot_q;
	logic       dimmed_q;

	logic             acc;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;
	func_t            func_c;
	logic [DIG_W-1:0] dig_idx;
	logic             digit_ok;
	logic [CH_W-1:0]  ci_idx;
	logic             char_ok;

	logic [NUM_DIGITS-1:0] vis_d;
	logic [15:0]           blink_timer_d;
	logic [7:0]            scan_cnt;
	logic                  scan_fire;
	logic [1:0]            sel_d;
	logic [6:0]            seg_d;
	logic                  dot_d;
	logic                  dimmed_d;
	logic                  lit_d;
	logic [3:0]            dim_d;
	logic [15:0]           scroll_cnt;
	logic                  scroll_fire;
	logic [POS_W-1:0]      pos_next;
	logic [6:0]            next_char;
	logic [7:0]            passes_inc;

	assign acc      = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall;
	assign func_c   = func_t'(func);
	assign dig_idx  = DIG_W'(digit);
	assign digit_ok = int'(digit) < NUM_DIGITS;
	assign ci_idx   = CH_W'(char_index);
	assign char_ok  = int'(char_index) < MESSAGE_CHARS;

	// APB: always ready, write on access phase
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_BRIGHTNESS:  prdata = {28'd0, brightness_q};
			REG_SCAN_PERIOD: prdata = {24'd0, scan_period_q};
			REG_BLINK_PER:   prdata = {16'd0, blink_period_q};
			REG_SCROLL_PER:  prdata = {16'd0, scroll_period_q};
			REG_BLINK_EN:    prdata = {31'd0, blink_en_q};
			REG_BLINK_DIGIT: prdata = {30'd0, blink_digit_q};
			default:         prdata = 32'd0;
		endcase
	end

	// blink engine: next visibility and timer
	always_comb begin
		vis_d         = vis_q;
		blink_timer_d = blink_timer_q;
		if (!blink_en_q) begin
			vis_d = '1;
		end else if (blink_timer_q > 16'd1) begin
			blink_timer_d = blink_timer_q - 16'd1;
		end else begin
			blink_timer_d = blink_period_q;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				if (int'(blink_digit_q) == i) vis_d[i] = ~vis_q[i];
				else vis_d[i] = 1'b1;
			end
		end
	end

	// scan step, then brightness limiter on the drive latch
	assign scan_cnt  = scan_timer_q + 8'd1;
	assign scan_fire = scan_cnt >= scan_period_q;

	always_comb begin
		sel_d    = sel_q;
		seg_d    = seg_q;
		dot_d    = dot_q;
		dimmed_d = dimmed_q;
		lit_d    = lit_q;
		dim_d    = dim_q;
		if (scan_fire) begin
			sel_d    = 2'(scan_index_q);
			seg_d    = vis_d[scan_index_q] ? pat_q[scan_index_q] : 7'd0;
			dot_d    = dots_q[scan_index_q];
			dimmed_d = 1'b0;
			lit_d    = 1'b1;
		end
		if ((int'(brightness_q) < BRIGHT_MAX) && lit_d) begin
			if (brightness_q <= dim_q) begin
				seg_d    = 7'd0;
				dot_d    = 1'b0;
				dimmed_d = 1'b1;
				lit_d    = 1'b0;
				dim_d    = 4'd0;
			end else begin
				dim_d = dim_q + 4'd1;
			end
		end
	end

	// scroll timing and the character that enters the window
	assign scroll_cnt  = scroll_timer_q + 16'd1;
	assign scroll_fire = scroll_cnt >= scroll_period_q;
	assign pos_next    = pos_q + POS_W'(1);
	assign next_char   = (int'(pos_next) < MESSAGE_CHARS) ? chars_q[CH_W'(pos_next)] : 7'd0;
	assign passes_inc  = passes_q + 8'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q    <= BRIGHT_RST;
			scan_period_q   <= SCAN_PER_RST;
			blink_period_q  <= BLINK_PER_RST;
			scroll_period_q <= SCROLL_PER_RST;
			blink_en_q      <= 1'b0;
			blink_digit_q   <= 2'd0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BRIGHTNESS:  brightness_q    <= pwdata[3:0];
				REG_SCAN_PERIOD: scan_period_q   <= pwdata[7:0];
				REG_BLINK_PER:   blink_period_q  <= pwdata[15:0];
				REG_SCROLL_PER:  scroll_period_q <= pwdata[15:0];
				REG_BLINK_EN:    blink_en_q      <= pwdata[0];
				REG_BLINK_DIGIT: blink_digit_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// request processing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				pat_q[i] <= ALL_SEGS_ON;
				win_q[i] <= 7'd0;
			end
			for (int i = 0; i < MESSAGE_CHARS; i++) begin
				chars_q[i] <= 7'd0;
			end
			dots_q         <= '0;
			vis_q          <= '1;
			scan_index_q   <= '0;
			scan_timer_q   <= 8'd0;
			dim_q          <= 4'd0;
			lit_q          <= 1'b0;
			blink_timer_q  <= BLINK_PER_RST;
			scroll_timer_q <= 16'd0;
			pos_q          <= '0;
			passes_q       <= 8'd0;
			limit_q        <= SCROLL_LIM_RST;
			active_q       <= 1'b0;
			sel_q          <= 2'd0;
			seg_q          <= 7'd0;
			dot_q          <= 1'b0;
			dimmed_q       <= 1'b0;
		end else if (acc) begin
			unique case (func_c)
				FUNC_TICK: begin
					vis_q         <= vis_d;
					blink_timer_q <= blink_timer_d;
					scan_timer_q  <= scan_fire ? 8'd0 : scan_cnt;
					if (scan_fire) begin
						scan_index_q <= (int'(scan_index_q) >= NUM_DIGITS - 1) ?
							'0 : scan_index_q + DIG_W'(1);
					end
					sel_q    <= sel_d;
					seg_q    <= seg_d;
					dot_q    <= dot_d;
					dimmed_q <= dimmed_d;
					lit_q    <= lit_d;
					dim_q    <= dim_d;
					scroll_timer_q <= scroll_fire ? 16'd0 : scroll_cnt;
					// scroll advance: copy window, then move it
					if (scroll_fire && active_q) begin
						for (int i = 0; i < NUM_DIGITS; i++) begin
							pat_q[i] <= win_q[i];
						end
						if (int'(pos_q) < LAST_POS) begin
							pos_q <= pos_next;
							for (int i = 0; i < NUM_DIGITS - 1; i++) begin
								win_q[i] <= win_q[i+1];
							end
							win_q[NUM_DIGITS-1] <= next_char;
						end else begin
							pos_q <= '0;
							for (int i = 0; i < NUM_DIGITS - 1; i++) begin
								win_q[i] <= 7'd0;
							end
							win_q[NUM_DIGITS-1] <= chars_q[0];
							if (passes_inc == limit_q) begin
								active_q <= 1'b0;
								passes_q <= 8'd0;
							end else begin
								passes_q <= passes_inc;
							end
						end
					end
				end
				FUNC_WR_DIGIT: begin
					if (digit_ok) pat_q[dig_idx] <= pattern;
				end
				FUNC_WR_DOT: begin
					if (digit_ok) dots_q[dig_idx] <= dot_level;
				end
				FUNC_LOAD_CHAR: begin
					if (char_ok) begin
						chars_q[ci_idx] <= pattern;
						// keep the window in step with the message
						for (int i = 0; i < NUM_DIGITS; i++) begin
							if (int'(pos_q) + i == int'(char_index) + LEAD) win_q[i] <= pattern;
						end
					end
				end
				FUNC_START_SCRL: begin
					active_q <= 1'b1;
					limit_q  <= repeat_count;
					pos_q    <= '0;
					passes_q <= 8'd0;
					for (int i = 0; i < NUM_DIGITS - 1; i++) begin
						win_q[i] <= 7'd0;
					end
					win_q[NUM_DIGITS-1] <= chars_q[0];
				end
				FUNC_STOP_SCRL: begin
					active_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_select = sel_q;
	assign segments     = seg_q;
	assign dot_out      = dot_q;
	assign dimmed       = dimmed_q;
	assign scroll_busy  = active_q;

`ifndef SYNTH
	// a dimmed digit drives nothing
	a_dim_blank: assert property (@(posedge clk) disable iff (!arst_n)
		dimmed_q |-> (seg_q == 7'd0) && !dot_q)
		else $error("dimmed digit still drives segments");

	// a start request always leaves the scroll engine running
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (func_c == FUNC_START_SCRL) |=> active_q)
		else $error("scroll not active after start");

	// requests are held back only while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("request stalled with empty result register");

	// scan index stays within the digit count
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(scan_index_q) < NUM_DIGITS)
		else $error("scan index out of range");

	// scroll position moves only on a request
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(pos_q))
		else $error("scroll position changed without a request");
`endif

endmodule : seven_segment_scan_blink_scroll

`default_nettype wire
